/* hw/rtl/rbcc_pkg.sv */
// shared constants for the rotated box corner calculator
package rbcc_pkg;

    localparam int GRID_SHIFT      = 5;
    localparam int ANGLE_FRAC_BITS = 6;

    localparam int ANGLE_W   = 15;
    localparam int POS_W     = 16;
    localparam int SIZE_W    = 11;
    localparam int HALF_W    = 10;
    localparam int VEC_W     = 11;
    localparam int CORNER_W  = 17;
    localparam int GRID_W    = 12;

    localparam int SIZE_RESET  = 32;
    localparam int PIPE_STAGES = 9;

    localparam int QUARTER_TURN = 90 << ANGLE_FRAC_BITS;
    localparam int FULL_TURN    = 360 << ANGLE_FRAC_BITS;
    localparam int TURN_W       = $clog2(FULL_TURN + 1);
    localparam int QTR_W        = $clog2(QUARTER_TURN + 1);

    localparam logic [28:0] COEF_A1 = 29'd421657428;
    localparam logic [27:0] COEF_A3 = 28'd172226216;
    localparam logic [24:0] COEF_A5 = 25'd19004244;

    // z = (r << 15) / QUARTER_TURN as multiply by reciprocal plus correction
    localparam int RECIP_SH = 40;
    localparam longint RECIP = ((64'd1 << RECIP_SH) + QUARTER_TURN - 1) / QUARTER_TURN;

    localparam int CFG_BOX_WIDTH  = 0;
    localparam int CFG_BOX_HEIGHT = 1;
    localparam int CFG_IDX_W      = 1;

    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 176;

endpackage

/* hw/rtl/rotated_box_corner_calc_core.sv */
// top level: pipelined rotated box corner and grid cell calculator
//
// usage: one item per transfer on s_axis (pos_x, pos_y, angle), one result
// per item on m_axis. box_width and box_height are set through the cfg
// channel (index 0 and 1); the user must do so only while the block is idle,
// which the block itself does not enforce; both reset to 32. the datapath is
// a 9 stage pipeline, and one item is taken every cycle while the output is
// not stalled. the depth is set by the sine polynomial, whose four chained
// multiplies each take one stage, plus angle reduction, quadrant folding,
// reciprocal division and scaling stages. the pipeline advances only when
// its output register is free or being taken, so a receiver stall holds
// every stage and s_axis_tready goes low; nothing is lost or repeated.
// synchronous active-low reset clears all valid bits and restores the
// configuration registers; cfg_ready is always high.
module rotated_box_corner_calc_core (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // pos_x[15:0], pos_y[31:16], angle[46:32], zero [47]
    input  logic [rbcc_pkg::IN_DATA_W-1:0] s_axis_tdata,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // half_w_dx[10:0] half_w_dy[21:11] half_h_dx[32:22] half_h_dy[43:33]
    // corner_a_x[60:44] corner_a_y[77:61] corner_b_x[94:78] corner_b_y[111:95]
    // corner_c_x[128:112] corner_c_y[145:129] grid_col[157:146]
    // grid_row[169:158], zero [175:170]
    output logic [rbcc_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [rbcc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [rbcc_pkg::SIZE_W-1:0]    cfg_data
);

    logic [rbcc_pkg::SIZE_W-1:0] bw_reg, bh_reg;
    logic adv;
    logic [rbcc_pkg::PIPE_STAGES-1:0] v_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bw_reg <= rbcc_pkg::SIZE_W'(rbcc_pkg::SIZE_RESET);
            bh_reg <= rbcc_pkg::SIZE_W'(rbcc_pkg::SIZE_RESET);
        end else if (cfg_valid) begin
            if (cfg_index == rbcc_pkg::CFG_IDX_W'(rbcc_pkg::CFG_BOX_WIDTH))
                bw_reg <= cfg_data;
            else if (cfg_index == rbcc_pkg::CFG_IDX_W'(rbcc_pkg::CFG_BOX_HEIGHT))
                bh_reg <= cfg_data;
        end
    end

    assign adv = !v_reg[rbcc_pkg::PIPE_STAGES-1] || m_axis_tready;
    assign s_axis_tready = adv;
    assign m_axis_tvalid = v_reg[rbcc_pkg::PIPE_STAGES-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (adv) begin
            v_reg <= {v_reg[rbcc_pkg::PIPE_STAGES-2:0], s_axis_tvalid};
        end
    end

    logic [rbcc_pkg::HALF_W-1:0] hw, hh;
    assign hw = bw_reg[rbcc_pkg::SIZE_W-1:1];
    assign hh = bh_reg[rbcc_pkg::SIZE_W-1:1];

    // position, carried alongside, and the grid outputs
    logic signed [rbcc_pkg::POS_W-1:0] px_p [rbcc_pkg::PIPE_STAGES-1];
    logic signed [rbcc_pkg::POS_W-1:0] py_p [rbcc_pkg::PIPE_STAGES-1];
    logic signed [rbcc_pkg::GRID_W-1:0] gc_reg, gr_reg;

    // stage 1: angle reduction for sine and cosine
    logic [rbcc_pkg::TURN_W-1:0] a1_reg, c1_reg;
    // stage 2: quadrant and offset
    logic [rbcc_pkg::QTR_W-1:0] rs2_reg, rc2_reg;
    logic ns2_reg, nc2_reg;
    logic ns_p [3:8];
    logic nc_p [3:8];
    // stage 3: reciprocal product, offset kept for the division correction
    logic [63:0] zs3_reg, zc3_reg;
    logic [rbcc_pkg::QTR_W-1:0] r3s_reg, r3c_reg;
    // stage 4: z
    logic [16:0] zs4_reg, zc4_reg;
    // stage 5: z2
    logic [16:0] zs5_reg, zc5_reg, qs5_reg, qc5_reg;
    // stage 6: u
    logic [27:0] us6_reg, uc6_reg;
    logic [16:0] zs6_reg, zc6_reg, qs6_reg, qc6_reg;
    // stage 7: p
    logic [28:0] ps7_reg, pc7_reg;
    logic [16:0] zs7_reg, zc7_reg;
    // stage 8: magnitudes
    logic [16:0] ms8_reg, mc8_reg;

    logic [rbcc_pkg::ANGLE_W-1:0] ang;
    assign ang = s_axis_tdata[46:32];

    function automatic logic [rbcc_pkg::TURN_W-1:0] mod_turn(input logic [16:0] a);
        logic [16:0] t;
        t = a;
        if (t >= 17'(rbcc_pkg::FULL_TURN)) t = t - 17'(rbcc_pkg::FULL_TURN);
        if (t >= 17'(rbcc_pkg::FULL_TURN)) t = t - 17'(rbcc_pkg::FULL_TURN);
        return rbcc_pkg::TURN_W'(t);
    endfunction

    function automatic logic [rbcc_pkg::QTR_W:0] quad_off(
        input logic [rbcc_pkg::TURN_W-1:0] a);
        // returns {neg, offset} with odd quadrants mirrored
        logic [rbcc_pkg::TURN_W-1:0] r;
        logic neg;
        logic odd;
        neg = a >= rbcc_pkg::TURN_W'(2 * rbcc_pkg::QUARTER_TURN);
        r = neg ? a - rbcc_pkg::TURN_W'(2 * rbcc_pkg::QUARTER_TURN) : a;
        odd = r >= rbcc_pkg::TURN_W'(rbcc_pkg::QUARTER_TURN);
        if (odd) r = rbcc_pkg::TURN_W'(2 * rbcc_pkg::QUARTER_TURN) - r;
        return {neg, rbcc_pkg::QTR_W'(r)};
    endfunction

    function automatic logic [16:0] z_fix(input logic [63:0] prod,
                                          input logic [rbcc_pkg::QTR_W-1:0] r);
        logic [16:0] z;
        logic [40:0] num;
        logic [40:0] back;
        z = prod[rbcc_pkg::RECIP_SH +: 17];
        num = 41'(r) << 15;
        back = 41'(z) * 41'(rbcc_pkg::QUARTER_TURN);
        if (back > num) z = z - 17'd1;
        return z;
    endfunction

    function automatic logic [16:0] mag_sat(input logic [45:0] pz);
        logic [17:0] s;
        s = pz[45:28];
        return (s > 18'd32768) ? 17'd32768 : s[16:0];
    endfunction

    logic [rbcc_pkg::QTR_W:0] qs, qc;
    assign qs = quad_off(a1_reg);
    assign qc = quad_off(c1_reg);

    always_ff @(posedge aclk) begin
        if (adv) begin
            a1_reg <= mod_turn(17'(ang));
            c1_reg <= mod_turn(17'(ang) + 17'(rbcc_pkg::QUARTER_TURN));
            px_p[0] <= s_axis_tdata[15:0];
            py_p[0] <= s_axis_tdata[31:16];
            for (int i = 1; i < rbcc_pkg::PIPE_STAGES - 1; i++) begin
                px_p[i] <= px_p[i-1];
                py_p[i] <= py_p[i-1];
            end
            {ns2_reg, rs2_reg} <= qs;
            {nc2_reg, rc2_reg} <= qc;
            zs3_reg <= 64'(rs2_reg) * 64'(rbcc_pkg::RECIP << 15);
            zc3_reg <= 64'(rc2_reg) * 64'(rbcc_pkg::RECIP << 15);
            r3s_reg <= rs2_reg;
            r3c_reg <= rc2_reg;
            ns_p[3] <= ns2_reg;
            nc_p[3] <= nc2_reg;
            for (int i = 4; i <= 8; i++) begin
                ns_p[i] <= ns_p[i-1];
                nc_p[i] <= nc_p[i-1];
            end
            zs4_reg <= z_fix(zs3_reg, r3s_reg);
            zc4_reg <= z_fix(zc3_reg, r3c_reg);
            zs5_reg <= zs4_reg;
            zc5_reg <= zc4_reg;
            qs5_reg <= 17'((34'(zs4_reg) * 34'(zs4_reg)) >> 15);
            qc5_reg <= 17'((34'(zc4_reg) * 34'(zc4_reg)) >> 15);
            us6_reg <= rbcc_pkg::COEF_A3 - 28'((42'(rbcc_pkg::COEF_A5) * 42'(qs5_reg)) >> 15);
            uc6_reg <= rbcc_pkg::COEF_A3 - 28'((42'(rbcc_pkg::COEF_A5) * 42'(qc5_reg)) >> 15);
            zs6_reg <= zs5_reg;
            zc6_reg <= zc5_reg;
            qs6_reg <= qs5_reg;
            qc6_reg <= qc5_reg;
            ps7_reg <= rbcc_pkg::COEF_A1 - 29'((45'(us6_reg) * 45'(qs6_reg)) >> 15);
            pc7_reg <= rbcc_pkg::COEF_A1 - 29'((45'(uc6_reg) * 45'(qc6_reg)) >> 15);
            zs7_reg <= zs6_reg;
            zc7_reg <= zc6_reg;
            ms8_reg <= mag_sat(46'(ps7_reg) * 46'(zs7_reg));
            mc8_reg <= mag_sat(46'(pc7_reg) * 46'(zc7_reg));
        end
    end

    // stage 9: scaling, corners and grid
    logic [26:0] pwx, pwy, phx, phy;
    // vectors kept one bit wider so corners see the unwrapped values
    logic signed [rbcc_pkg::VEC_W:0] wdx, wdy, hdx, hdy;
    logic signed [rbcc_pkg::CORNER_W-1:0] cx, cy;
    logic signed [rbcc_pkg::CORNER_W+1:0] gx, gy;
    logic [rbcc_pkg::CORNER_W+1:0] gxm, gym;
    logic [rbcc_pkg::GRID_W-1:0] gcx, gcy;

    assign pwx = 27'(mc8_reg) * 27'(hw);
    assign pwy = 27'(ms8_reg) * 27'(hw);
    assign phx = 27'(ms8_reg) * 27'(hh);
    assign phy = 27'(mc8_reg) * 27'(hh);

    always_comb begin
        wdx = nc_p[8] ? -$signed({1'b0, pwx[25:15]}) : $signed({1'b0, pwx[25:15]});
        wdy = ns_p[8] ? -$signed({1'b0, pwy[25:15]}) : $signed({1'b0, pwy[25:15]});
        hdx = ns_p[8] ? $signed({1'b0, phx[25:15]}) : -$signed({1'b0, phx[25:15]});
        hdy = nc_p[8] ? -$signed({1'b0, phy[25:15]}) : $signed({1'b0, phy[25:15]});
        cx = rbcc_pkg::CORNER_W'(px_p[rbcc_pkg::PIPE_STAGES-2]) + $signed({7'd0, hw});
        cy = rbcc_pkg::CORNER_W'(py_p[rbcc_pkg::PIPE_STAGES-2]) + $signed({7'd0, hh});
        gx = ($signed(19'(px_p[rbcc_pkg::PIPE_STAGES-2])) <<< 1) + $signed({8'd0, bw_reg});
        gy = ($signed(19'(py_p[rbcc_pkg::PIPE_STAGES-2])) <<< 1) + $signed({8'd0, bh_reg});
        gxm = gx[18] ? 19'(-gx) : 19'(gx);
        gym = gy[18] ? 19'(-gy) : 19'(gy);
        gcx = 12'(gxm >> (rbcc_pkg::GRID_SHIFT + 1));
        gcy = 12'(gym >> (rbcc_pkg::GRID_SHIFT + 1));
    end

    logic signed [rbcc_pkg::VEC_W-1:0] owdx_reg, owdy_reg, ohdx_reg, ohdy_reg;
    logic signed [rbcc_pkg::CORNER_W-1:0] ax_reg, ay_reg, bx_reg, by_reg, cx_reg, cy_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            owdx_reg <= wdx[rbcc_pkg::VEC_W-1:0];
            owdy_reg <= wdy[rbcc_pkg::VEC_W-1:0];
            ohdx_reg <= hdx[rbcc_pkg::VEC_W-1:0];
            ohdy_reg <= hdy[rbcc_pkg::VEC_W-1:0];
            ax_reg <= cx - 17'(wdx) - 17'(hdx);
            ay_reg <= cy - 17'(wdy) - 17'(hdy);
            bx_reg <= cx + 17'(wdx) - 17'(hdx);
            by_reg <= cy + 17'(wdy) - 17'(hdy);
            cx_reg <= cx - 17'(wdx) + 17'(hdx);
            cy_reg <= cy - 17'(wdy) + 17'(hdy);
            gc_reg <= gx[18] ? -$signed(gcx) : $signed(gcx);
            gr_reg <= gy[18] ? -$signed(gcy) : $signed(gcy);
        end
    end

    assign m_axis_tdata = {6'd0, gr_reg, gc_reg, cy_reg, cx_reg, by_reg, bx_reg,
                           ay_reg, ax_reg, ohdy_reg, ohdx_reg, owdy_reg, owdx_reg};

endmodule

/* hw/rtl/rbcc_checker.sv */
// port-level assertions for the rotated box corner calculator
module rbcc_checker (
    input logic aclk,
    input logic aresetn,
    input logic s_axis_tvalid,
    input logic s_axis_tready,
    input logic m_axis_tvalid,
    input logic m_axis_tready
);
    a_stall_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready) else $error("stall");
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid) else $error("drop");
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_axis_tvalid |-> s_axis_tready) else $error("ready");
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid) else $error("reset");
endmodule

bind rotated_box_corner_calc_core rbcc_checker u_chk (.*);
